// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
// Each macro takes a label, the clock, the active-low reset, a condition
// and the property that must follow from it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/htsc_pkg.sv -----
// ----------------------------------------------------------------------------
// htsc_pkg
// Types, character codes and script text constants of the page converter.
// ----------------------------------------------------------------------------
package htsc_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_end;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       script_done;
  } out_beat_t;

  // Output segments, in the order they are sent within one item.
  localparam int NSEG  = 8;
  localparam int SEG_W = 3;
  localparam logic [SEG_W-1:0] SEG_HDR     = 3'd0;
  localparam logic [SEG_W-1:0] SEG_RAWOPEN = 3'd1;
  localparam logic [SEG_W-1:0] SEG_LT      = 3'd2;
  localparam logic [SEG_W-1:0] SEG_PCT     = 3'd3;
  localparam logic [SEG_W-1:0] SEG_EMOPEN  = 3'd4;
  localparam logic [SEG_W-1:0] SEG_CHR     = 3'd5;
  localparam logic [SEG_W-1:0] SEG_CLOSE   = 3'd6;
  localparam logic [SEG_W-1:0] SEG_EMCLOSE = 3'd7;

  localparam int OFF_W = 4;

  // One classified item: which segments to send and the data byte.
  typedef struct packed {
    logic [NSEG-1:0] segs;
    logic            chr_esc;
    logic [7:0]      chr_byte;
    logic            is_end;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_port_t;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_N    = 8'h6E;

  localparam logic [7:0] HDR_TXT [10] = '{"u", "s", "e", " ", "h", "t", "t", "p", ";", 8'h0A};
  localparam logic [7:0] RAWOPEN_TXT [15] = '{"W", "r", "i", "t", "e", "H", "t", "m", "l",
                                              "R", "a", "w", "(", " ", 8'h22};
  localparam logic [7:0] EMOPEN_TXT [14] = '{"W", "r", "i", "t", "e", "H", "t", "m", "l",
                                             "R", "a", "w", "(", " "};
  localparam logic [7:0] CLOSE_TXT [4]   = '{8'h22, ")", ";", 8'h0A};
  localparam logic [7:0] EMCLOSE_TXT [4] = '{" ", ")", ";", 8'h0A};

  // Lowest pending segment of a mask.
  function automatic logic [SEG_W-1:0] first_seg(input logic [NSEG-1:0] m);
    logic [SEG_W-1:0] r;
    r = '0;
    for (int i = NSEG - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = SEG_W'(i);
      end
    end
    return r;
  endfunction

  // Offset of the final byte of a fixed segment.
  function automatic logic [OFF_W-1:0] seg_last(input logic [SEG_W-1:0] seg);
    logic [OFF_W-1:0] r;
    unique case (seg)
      SEG_HDR:     r = 4'd9;
      SEG_RAWOPEN: r = 4'd14;
      SEG_EMOPEN:  r = 4'd13;
      SEG_CLOSE:   r = 4'd3;
      SEG_EMCLOSE: r = 4'd3;
      default:     r = 4'd0;
    endcase
    return r;
  endfunction

  // Byte of a fixed segment at an offset.
  function automatic logic [7:0] seg_const_byte(input logic [SEG_W-1:0] seg,
                                                input logic [OFF_W-1:0] off);
    logic [7:0] r;
    unique case (seg)
      SEG_HDR:     r = HDR_TXT[off];
      SEG_RAWOPEN: r = RAWOPEN_TXT[off];
      SEG_LT:      r = CH_LT;
      SEG_PCT:     r = CH_PCT;
      SEG_EMOPEN:  r = EMOPEN_TXT[off];
      SEG_CLOSE:   r = CLOSE_TXT[off[1:0]];
      SEG_EMCLOSE: r = EMCLOSE_TXT[off[1:0]];
      default:     r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/htsc_front.sv -----
// ----------------------------------------------------------------------------
// htsc_front
// Accepts page bytes, tracks the parse state and classifies each beat.
// ----------------------------------------------------------------------------
module htsc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  htsc_pkg::in_beat_t  in_data,
  input  logic                q_full,
  output htsc_pkg::job_port_t push
);
  import htsc_pkg::*;

  logic header_sent_r, header_sent_nxt;
  logic in_code_r, in_code_nxt;
  logic held_lt_r, held_lt_nxt;
  logic held_pct_r, held_pct_nxt;
  logic just_opened_r, just_opened_nxt;
  logic emit_r, emit_nxt;
  logic tco_r, tco_nxt;

  logic       accept;
  logic [7:0] c;
  logic       is_end;
  job_t       job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign c        = in_data.in_byte;
  assign is_end   = in_data.is_end || (c == 8'h00);

  always_comb begin
    header_sent_nxt = 1'b1;
    in_code_nxt     = in_code_r;
    held_lt_nxt     = held_lt_r;
    held_pct_nxt    = held_pct_r;
    just_opened_nxt = just_opened_r;
    emit_nxt        = emit_r;
    tco_nxt         = tco_r;

    job                   = '0;
    job.segs[SEG_HDR]     = !header_sent_r;
    job.is_end            = is_end;
    job.chr_byte          = c;

    if (is_end) begin
      if (held_lt_r) begin
        job.segs[SEG_RAWOPEN] = !tco_r;
        job.segs[SEG_LT]      = 1'b1;
      end
      job.segs[SEG_PCT]   = held_pct_r;
      job.segs[SEG_CLOSE] = tco_r || held_lt_r;
      header_sent_nxt = 1'b0;
      in_code_nxt     = 1'b0;
      held_lt_nxt     = 1'b0;
      held_pct_nxt    = 1'b0;
      just_opened_nxt = 1'b0;
      emit_nxt        = 1'b0;
      tco_nxt         = 1'b0;
    end else if (in_code_r) begin
      if (just_opened_r) begin
        just_opened_nxt = 1'b0;
        if (c == CH_EQ) begin
          emit_nxt               = 1'b1;
          job.segs[SEG_EMOPEN]   = 1'b1;
        end else if (c == CH_PCT) begin
          held_pct_nxt = 1'b1;
        end else begin
          job.segs[SEG_CHR] = 1'b1;
        end
      end else if (held_pct_r) begin
        held_pct_nxt = 1'b0;
        if (c == CH_GT) begin
          in_code_nxt           = 1'b0;
          job.segs[SEG_EMCLOSE] = emit_r;
          emit_nxt              = 1'b0;
        end else begin
          job.segs[SEG_PCT] = 1'b1;
          if (c == CH_PCT) begin
            held_pct_nxt = 1'b1;
          end else begin
            job.segs[SEG_CHR] = 1'b1;
          end
        end
      end else if (c == CH_PCT) begin
        held_pct_nxt = 1'b1;
      end else begin
        job.segs[SEG_CHR] = 1'b1;
      end
    end else begin
      if (held_lt_r && (c == CH_PCT)) begin
        held_lt_nxt         = 1'b0;
        job.segs[SEG_CLOSE] = tco_r;
        tco_nxt             = 1'b0;
        in_code_nxt         = 1'b1;
        just_opened_nxt     = 1'b1;
      end else begin
        // A held '<' that starts no code region goes out as text first.
        if (held_lt_r) begin
          job.segs[SEG_LT] = 1'b1;
        end
        held_lt_nxt = (c == CH_LT);
        if ((c != CH_LT) && (c != CH_CR)) begin
          job.segs[SEG_CHR] = 1'b1;
          job.chr_esc       = (c == CH_QUOT) || (c == CH_NL);
          job.chr_byte      = (c == CH_NL) ? CH_N : c;
        end
        if (job.segs[SEG_LT] || job.segs[SEG_CHR]) begin
          job.segs[SEG_RAWOPEN] = !tco_r;
          tco_nxt               = 1'b1;
        end
      end
    end
  end

  assign push.valid = accept;
  assign push.job   = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_sent_r <= 1'b0;
      in_code_r     <= 1'b0;
      held_lt_r     <= 1'b0;
      held_pct_r    <= 1'b0;
      just_opened_r <= 1'b0;
      emit_r        <= 1'b0;
      tco_r         <= 1'b0;
    end else if (accept) begin
      header_sent_r <= header_sent_nxt;
      in_code_r     <= in_code_nxt;
      held_lt_r     <= held_lt_nxt;
      held_pct_r    <= held_pct_nxt;
      just_opened_r <= just_opened_nxt;
      emit_r        <= emit_nxt;
      tco_r         <= tco_nxt;
    end
  end

endmodule

// ----- hw/rtl/htsc_queue.sv -----
// ----------------------------------------------------------------------------
// htsc_queue
// Short job queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module htsc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  htsc_pkg::job_port_t push,
  input  logic                pop,
  output logic                full,
  output htsc_pkg::job_port_t head
);
  import htsc_pkg::*;

  job_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full       = (cnt_r == (Q_AW + 1)'(Q_DEPTH));
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && (cnt_r != '0);
  assign head.valid = (cnt_r != '0);
  assign head.job   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/htsc_back.sv -----
// ----------------------------------------------------------------------------
// htsc_back
// Walks the segments of the head job and sends one script byte per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module htsc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  htsc_pkg::job_port_t  head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output htsc_pkg::out_beat_t  out_data
);
  import htsc_pkg::*;

  logic [NSEG-1:0]  done_r, done_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic             out_valid_r;
  out_beat_t        out_data_r;

  logic [NSEG-1:0]  rem, rest;
  logic [SEG_W-1:0] seg;
  logic [OFF_W-1:0] last_off;
  logic             empty_job, last_in_seg, last, load_ok, fire;
  out_beat_t        beat;

  assign rem         = head.job.segs & ~done_r;
  assign seg         = first_seg(rem);
  assign empty_job   = (rem == '0);
  assign last_off    = (seg == SEG_CHR) ? {3'b000, head.job.chr_esc} : seg_last(seg);
  assign last_in_seg = (off_r == last_off);
  assign rest        = rem & ~(NSEG'(1) << seg);
  assign last        = empty_job || (last_in_seg && (rest == '0));
  assign load_ok     = !out_valid_r || out_ready;
  assign fire        = head.valid && load_ok;
  assign pop         = fire && last;

  always_comb begin
    beat = '0;
    if (!empty_job) begin
      beat.byte_valid = 1'b1;
      if (seg == SEG_CHR) begin
        beat.out_byte = (head.job.chr_esc && (off_r == '0)) ? CH_BSL : head.job.chr_byte;
      end else begin
        beat.out_byte = seg_const_byte(seg, off_r);
      end
    end
    beat.last_of_run = last;
    beat.script_done = last && head.job.is_end;
  end

  always_comb begin
    done_nxt = done_r;
    off_nxt  = off_r;
    if (fire) begin
      if (last) begin
        done_nxt = '0;
        off_nxt  = '0;
      end else if (last_in_seg) begin
        done_nxt = done_r | (NSEG'(1) << seg);
        off_nxt  = '0;
      end else begin
        off_nxt = off_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      off_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
      off_r  <= off_nxt;
      if (load_ok) begin
        out_valid_r <= head.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/html_template_to_script_converter_unit.sv -----
// ----------------------------------------------------------------------------
// html_template_to_script_converter_unit
// Converts a template page, byte by byte, into script text.
// ----------------------------------------------------------------------------
// Usage: page bytes arrive on the in_ channel (in_valid / in_ready, payload
// in_data) and script bytes leave on the out_ channel (out_valid /
// out_ready, payload out_data), one byte per beat. Every input beat yields
// one or more output beats; the final one carries last_of_run, and an input
// beat that produces no text yields a single beat with byte_valid low.
// An input beat with is_end set or a zero byte ends the page: held markers
// are flushed, an open raw-write call is closed, script_done marks the final
// output beat, and the parser rearms for the next page, header included.
// Path: with the queue empty, an accepted input beat is written into the job
// queue, and its first output beat is then loaded into the output register,
// where the receiver can take it.
// Throughput: while the receiver is ready, the output register sends one byte
// per cycle; an input beat produces 1 to 30 bytes, so beats that produce one
// byte flow at one per cycle. A four-entry job queue lets the
// input run ahead of a long burst or a stalled receiver, and in_ready drops
// only when that queue is full.
// Reset: synchronous, active low; clears the parse state, the queue and the
// output valid flag. A stalled receiver simply holds the current output beat.
// ----------------------------------------------------------------------------
module html_template_to_script_converter_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  htsc_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output htsc_pkg::out_beat_t out_data
);
  import htsc_pkg::*;

  // Classified jobs flow from the front end into the queue.
  job_port_t push;
  // The head of the queue is what the sequencer is working on.
  job_port_t head;
  logic      q_full;
  logic      pop;

  // Front end: parse state and one job per accepted page byte.
  htsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push)
  );

  // Decoupling queue, so the front end can stall independently of the output.
  htsc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  // Back end: emits the segments of the head job, one byte per cycle while the
  // receiver is ready, and pops the job with its final byte.
  htsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/htsc_checker.sv -----
// ----------------------------------------------------------------------------
// htsc_checker
// Port-level checks of the page converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htsc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input htsc_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input htsc_pkg::out_beat_t out_data
);
  import htsc_pkg::*;

  logic in_fire;
  logic stalled;

  assign in_fire = in_valid && in_ready && (in_data.in_byte != 8'h00);
  assign stalled = out_valid && !out_ready;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, out_valid && $stable(out_data))
  `ASSERT_SAME(a_done_is_last, clk, rst_n, out_valid && out_data.script_done, out_data.last_of_run)
  `ASSERT_SAME(a_empty_beat, clk, rst_n, out_valid && !out_data.byte_valid, out_data.last_of_run && (out_data.out_byte == 8'h00))
  `ASSERT_SAME(a_reset_quiet, clk, rst_n, $past(!rst_n), !out_valid)
  `ASSERT_NEXT(a_no_out_from_nothing, clk, rst_n, !out_valid && !in_fire && !in_valid && $past(!rst_n), !out_valid)

endmodule

bind html_template_to_script_converter_unit htsc_checker u_htsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- bench/html_template_to_script_converter_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_template_to_script_converter_unit_tb
// Checks the page-to-script converter beat by beat against a local model of
// the parser. A short directed table covers the markers, the escapes and the
// page-end cases. Random pages follow, mostly well-formed text and code
// regions, with some noise, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module html_template_to_script_converter_unit_tb;
  import htsc_pkg::*;

  localparam int RUN_BEATS    = 480;
  localparam int MAX_BURST    = 30;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  localparam string HDR_STR      = "use http;\n";
  localparam string RAW_OPEN_STR = "WriteHtmlRaw( \"";
  localparam string RAW_SHUT_STR = "\");\n";
  localparam string EMIT_OPEN_STR = "WriteHtmlRaw( ";
  localparam string EMIT_SHUT_STR = " );\n";

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  html_template_to_script_converter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Parser model. These bits track the same page state as the block: whether
  // the header went out, whether we sit inside a code region, the one-byte
  // lookahead for '<' and '%', and the open raw-write or emit calls.
  // --------------------------------------------------------------------------
  bit hdr_done;
  bit code_mode;
  bit lt_pending;
  bit pct_pending;
  bit code_fresh;
  bit emit_mode;
  bit raw_open;

  out_beat_t burst_q[$];   // beats produced by the item being modeled
  out_beat_t script_q[$];  // script beats still owed by the block
  int        miss_cnt;

  function void clear_parser();
    hdr_done    = 1'b0;
    code_mode   = 1'b0;
    lt_pending  = 1'b0;
    pct_pending = 1'b0;
    code_fresh  = 1'b0;
    emit_mode   = 1'b0;
    raw_open    = 1'b0;
  endfunction

  // One script byte. The block never emits more than thirty per item.
  function void put_char(input logic [7:0] b);
    out_beat_t ob;
    if (burst_q.size() < MAX_BURST) begin
      ob = '0;
      ob.out_byte   = b;
      ob.byte_valid = 1'b1;
      burst_q.push_back(ob);
    end
  endfunction

  function void put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put_char(s[i]);
    end
  endfunction

  function void shut_raw();
    if (raw_open) begin
      put_text(RAW_SHUT_STR);
      raw_open = 1'b0;
    end
  endfunction

  // A kept byte of page text. The raw-write prefix goes out lazily, so a run
  // of nothing but carriage returns never opens a call.
  function void text_char(input logic [7:0] c);
    if (c != CH_CR) begin
      if (!raw_open) begin
        put_text(RAW_OPEN_STR);
        raw_open = 1'b1;
      end
      if (c == CH_QUOT) begin
        put_char(CH_BSL);
        put_char(CH_QUOT);
      end else if (c == CH_NL) begin
        put_char(CH_BSL);
        put_char(CH_N);
      end else begin
        put_char(c);
      end
    end
  endfunction

  function void page_char(input logic [7:0] c);
    if (c == CH_LT) begin
      lt_pending = 1'b1;
    end else begin
      text_char(c);
    end
  endfunction

  function void code_char(input logic [7:0] c);
    if (c == CH_PCT) begin
      pct_pending = 1'b1;
    end else begin
      put_char(c);
    end
  endfunction

  // Works out the beats of one accepted item into burst_q.
  function void convert_beat(input in_beat_t b);
    logic [7:0] c;
    logic       fin;
    out_beat_t  tail;
    c   = b.in_byte;
    fin = b.is_end || (c == 8'h00);
    burst_q.delete();
    if (!hdr_done) begin
      put_text(HDR_STR);
      hdr_done = 1'b1;
    end
    if (fin) begin
      // Flush the lookahead, close a text call, leave code regions as they are.
      if (lt_pending) begin
        lt_pending = 1'b0;
        text_char(CH_LT);
      end
      if (pct_pending) begin
        pct_pending = 1'b0;
        put_char(CH_PCT);
      end
      shut_raw();
      clear_parser();
    end else if (code_mode) begin
      if (code_fresh) begin
        code_fresh = 1'b0;
        if (c == CH_EQ) begin
          emit_mode = 1'b1;
          put_text(EMIT_OPEN_STR);
        end else begin
          code_char(c);
        end
      end else if (pct_pending) begin
        pct_pending = 1'b0;
        if (c == CH_GT) begin
          code_mode = 1'b0;
          if (emit_mode) begin
            put_text(EMIT_SHUT_STR);
          end
          emit_mode = 1'b0;
        end else begin
          put_char(CH_PCT);
          code_char(c);
        end
      end else begin
        code_char(c);
      end
    end else if (lt_pending) begin
      lt_pending = 1'b0;
      if (c == CH_PCT) begin
        shut_raw();
        code_mode  = 1'b1;
        code_fresh = 1'b1;
      end else begin
        text_char(CH_LT);
        page_char(c);
      end
    end else begin
      page_char(c);
    end
    // An item with nothing to say still yields one empty beat.
    if (burst_q.size() == 0) begin
      burst_q.push_back('0);
    end
    tail = burst_q.pop_back();
    tail.last_of_run = 1'b1;
    tail.script_done = fin;
    burst_q.push_back(tail);
  endfunction

  // Records what an accepted item owes. Rows with a hand-written answer use
  // that answer; the model still runs on them so that its state stays in step.
  task predict_script(input in_beat_t b, input bit typed, input string want);
    out_beat_t ob;
    logic      fin;
    fin = b.is_end || (b.in_byte == 8'h00);
    convert_beat(b);
    if (typed) begin
      if (want.len() == 0) begin
        ob = '0;
        ob.last_of_run = 1'b1;
        ob.script_done = fin;
        script_q.push_back(ob);
      end
      for (int i = 0; i < want.len(); i++) begin
        ob = '0;
        ob.out_byte    = want[i];
        ob.byte_valid  = 1'b1;
        ob.last_of_run = (i == want.len() - 1);
        ob.script_done = fin && (i == want.len() - 1);
        script_q.push_back(ob);
      end
    end else begin
      foreach (burst_q[i]) begin
        script_q.push_back(burst_q[i]);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table. A row either carries the script text it must produce or
  // leaves the answer to the model.
  // --------------------------------------------------------------------------
  in_beat_t dir_q[$];
  bit       dir_typed[$];
  string    dir_want[$];

  task add_row(input logic [7:0] b, input logic e, input bit typed, input string want);
    in_beat_t r;
    r.in_byte = b;
    r.is_end  = e;
    dir_q.push_back(r);
    dir_typed.push_back(typed);
    dir_want.push_back(want);
  endtask

  task build_table();
    // First page: escapes, a dropped carriage return, a stray '<', then an
    // emit region with a '%' inside it, and a '<' still held at the end.
    add_row("A",     1'b0, 1'b1, "use http;\nWriteHtmlRaw( \"A");
    add_row(8'hFF,   1'b0, 1'b0, "");
    add_row(CH_QUOT, 1'b0, 1'b1, "\\\"");
    add_row(CH_NL,   1'b0, 1'b1, "\\n");
    add_row(CH_CR,   1'b0, 1'b1, "");
    add_row(CH_LT,   1'b0, 1'b1, "");
    add_row("b",     1'b0, 1'b1, "<b");
    add_row(CH_LT,   1'b0, 1'b1, "");
    add_row(CH_PCT,  1'b0, 1'b1, "\");\n");
    add_row(CH_EQ,   1'b0, 1'b1, "WriteHtmlRaw( ");
    add_row(CH_PCT,  1'b0, 1'b1, "");
    add_row("y",     1'b0, 1'b1, "%y");
    add_row(CH_PCT,  1'b0, 1'b1, "");
    add_row(CH_GT,   1'b0, 1'b1, " );\n");
    add_row(CH_LT,   1'b0, 1'b1, "");
    add_row(8'hFF,   1'b1, 1'b0, "");
    // A page that is nothing but a zero byte still gets its header.
    add_row(8'h00,   1'b0, 1'b1, "use http;\n");
    // An opener followed directly by the end is an empty code region.
    add_row(CH_LT,   1'b0, 1'b1, "use http;\n");
    add_row(CH_PCT,  1'b0, 1'b1, "");
    add_row(8'h00,   1'b1, 1'b1, "");
    // A '%' held inside code at the end is copied out.
    add_row(CH_LT,   1'b0, 1'b1, "use http;\n");
    add_row(CH_PCT,  1'b0, 1'b1, "");
    add_row(CH_PCT,  1'b0, 1'b1, "");
    add_row("Q",     1'b1, 1'b1, "%");
    add_row("x",     1'b0, 1'b1, "use http;\nWriteHtmlRaw( \"x");
  endtask

  // --------------------------------------------------------------------------
  // Random pages. Most are text runs and code regions with random content;
  // a few code regions never close, some pages run on into the next, and a
  // tenth of the pages are raw noise.
  // --------------------------------------------------------------------------
  in_beat_t stim_q[$];

  task push_byte(input logic [7:0] b, input logic e);
    in_beat_t r;
    r.in_byte = b;
    r.is_end  = e;
    stim_q.push_back(r);
  endtask

  function logic [7:0] text_pick();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(97, 122));
    if (r < 48) return 8'h20;
    if (r < 56) return CH_QUOT;
    if (r < 63) return CH_NL;
    if (r < 68) return CH_CR;
    if (r < 74) return CH_LT;
    if (r < 79) return CH_GT;
    if (r < 83) return CH_EQ;
    if (r < 87) return CH_PCT;
    return 8'($urandom_range(1, 255));
  endfunction

  function logic [7:0] code_pick();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 8'($urandom_range(97, 122));
    if (r < 58) return 8'h3B;
    if (r < 66) return CH_PCT;
    if (r < 72) return CH_GT;
    if (r < 77) return CH_QUOT;
    if (r < 82) return CH_NL;
    if (r < 86) return CH_LT;
    return 8'($urandom_range(1, 255));
  endfunction

  task gen_page();
    int unsigned nseg;
    int unsigned r;
    nseg = $urandom_range(1, 6);
    for (int s = 0; s < nseg; s++) begin
      if ($urandom_range(0, 1) == 0) begin
        repeat ($urandom_range(0, 8)) push_byte(text_pick(), 1'b0);
      end else begin
        push_byte(CH_LT, 1'b0);
        push_byte(CH_PCT, 1'b0);
        if ($urandom_range(0, 9) < 4) begin
          push_byte(CH_EQ, 1'b0);
        end
        repeat ($urandom_range(0, 8)) push_byte(code_pick(), 1'b0);
        if ($urandom_range(0, 9) != 0) begin
          push_byte(CH_PCT, 1'b0);
          push_byte(CH_GT, 1'b0);
        end
      end
    end
    r = $urandom_range(0, 19);
    if (r < 12) begin
      push_byte(8'($urandom_range(0, 255)), 1'b1);
    end else if (r < 17) begin
      push_byte(8'h00, 1'b0);
    end
  endtask

  task gen_noise();
    repeat ($urandom_range(1, 12)) begin
      push_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 19) == 0));
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender. Gaps come in windows: some windows send back to back, others mix
  // mostly short gaps with the odd long one.
  // --------------------------------------------------------------------------
  int unsigned calm_left;
  bit          calm;
  bit          hold_req;

  function int unsigned send_gap();
    int unsigned r;
    if (calm_left == 0) begin
      calm      = ($urandom_range(0, 3) == 0);
      calm_left = $urandom_range(20, 60);
    end
    calm_left--;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // Offers one beat and returns at the edge that takes it. Valid is only
  // dropped when a gap follows, so back-to-back beats keep it high.
  task send_beat(input in_beat_t b);
    int unsigned gap;
    gap = send_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin : stim_proc
    in_beat_t b;
    clear_parser();
    calm_left = 0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    miss_cnt  = 0;
    build_table();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < dir_q.size(); i++) begin
      send_beat(dir_q[i]);
      predict_script(dir_q[i], dir_typed[i], dir_want[i]);
    end

    while (stim_q.size() < RUN_BEATS) begin
      if ($urandom_range(0, 9) == 0) begin
        gen_noise();
      end else begin
        gen_page();
      end
    end
    // Ask the receiver for its long hold now that the random traffic starts;
    // the queue inside the block should fill and push back on the input.
    hold_req = 1'b1;
    while (stim_q.size() != 0) begin
      b = stim_q.pop_front();
      send_beat(b);
      predict_script(b, 1'b0, "");
    end
    in_valid <= 1'b0;

    while (script_q.size() != 0) @(posedge clk);
    // Anything that trickles out after this point shows up as unexpected.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (miss_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver. Ready comes in runs of random length with stalls between them,
  // plus one long hold, counted here, once the random part has begun.
  // --------------------------------------------------------------------------
  initial begin : rx_proc
    int unsigned n;
    bit          held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      n = ($urandom_range(0, 9) < 3) ? $urandom_range(30, 100) : $urandom_range(1, 6);
      out_ready <= 1'b1;
      repeat (n) @(posedge clk);
      n = $urandom_range(0, 9);
      if (n < 6) begin
        n = 0;
      end else if (n < 9) begin
        n = $urandom_range(1, 3);
      end else begin
        n = $urandom_range(10, 25);
      end
      if (n != 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check. Every beat taken from the block is matched against the
  // oldest owed beat, field by field.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (script_q.size() == 0) begin
        miss_cnt++;
        if (miss_cnt <= 10) begin
          $display("unexpected beat: byte %02h valid %b last %b done %b",
                   out_data.out_byte, out_data.byte_valid,
                   out_data.last_of_run, out_data.script_done);
        end
      end else begin
        want = script_q.pop_front();
        if (want.out_byte !== out_data.out_byte ||
            want.byte_valid !== out_data.byte_valid ||
            want.last_of_run !== out_data.last_of_run ||
            want.script_done !== out_data.script_done) begin
          miss_cnt++;
          if (miss_cnt <= 10) begin
            $display("beat mismatch at %0t: want byte %02h valid %b last %b done %b, got byte %02h valid %b last %b done %b",
                     $realtime, want.out_byte, want.byte_valid, want.last_of_run,
                     want.script_done, out_data.out_byte, out_data.byte_valid,
                     out_data.last_of_run, out_data.script_done);
          end
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run, even with every item at
  // thirty beats and each beat caught in a long receiver stall.
  initial begin : watchdog
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
